FILE: hw/rtl/e2q_pkg.sv
// Shared constants and the arctangent table for the Euler angle to quaternion converter.
package e2q_pkg;

	localparam int ANGLE_W = 17;
	localparam int QUAT_W = 16;
	localparam int DEF_ANGLE_FRAC_BITS = 8;
	localparam int DEF_OUT_FRAC_BITS = 14;
	localparam int DEF_CORDIC_STEPS = 16;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// Width of the cosine and sine values.
	localparam int CS_W = 34;

	function automatic logic [29:0] atan_q30(input int idx);
		logic [29:0] v;
		case (idx)
			0: v = 30'd843314856;
			1: v = 30'd497837829;
			2: v = 30'd263043836;
			3: v = 30'd133525158;
			4: v = 30'd67021686;
			5: v = 30'd33543515;
			6: v = 30'd16775850;
			7: v = 30'd8388437;
			8: v = 30'd4194282;
			9: v = 30'd2097149;
			10: v = 30'd1048575;
			11: v = 30'd524287;
			12: v = 30'd262143;
			13: v = 30'd131071;
			14: v = 30'd65535;
			15: v = 30'd32767;
			16: v = 30'd16383;
			17: v = 30'd8191;
			18: v = 30'd4095;
			19: v = 30'd2047;
			20: v = 30'd1023;
			21: v = 30'd511;
			22: v = 30'd255;
			23: v = 30'd127;
			24: v = 30'd63;
			25: v = 30'd31;
			26: v = 30'd15;
			27: v = 30'd7;
			28: v = 30'd3;
			29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/euler_to_quaternion.sv
// Top level of the Euler angle (yaw, pitch, roll) to unit quaternion converter.
// The input stream carries one word per angle triple: yaw, pitch and roll in
// signed degrees with ANGLE_FRAC_BITS fraction bits. The output stream carries
// one word per input word: the quaternion w, x, y, z, signed with
// OUT_FRAC_BITS fraction bits, saturated to plus or minus one.
// The block is a fixed pipeline and takes one word in every cycle while the
// receiver does not stall. Its stages are three stages of the reciprocal
// divider that scales the angle, a range fold register, one cell per CORDIC
// step, the sign fix, two product stages, the sum stage and the output
// register. When the receiver stalls, the whole pipeline holds and
// s_axis_tready falls until the output word is taken. Reset clears the
// valid bits, so no word is in flight afterwards; the data registers are
// not reset.
module euler_to_quaternion import e2q_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // yaw_angle, pitch_angle, roll_angle, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z
);

	localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int LAT = N + 9;
	localparam int PW = 2 * CS_W;
	localparam int SW = PW + 2;
	localparam int SH = 60 - OUT_FRAC_BITS;
	localparam logic signed [SW-1:0] HALF_LSB = SW'(1) <<< (SH - 1);
	localparam logic signed [SW-1:0] LIM = SW'(1) <<< OUT_FRAC_BITS;
	localparam logic signed [SW-1:0] Q_MAX = SW'(32767);
	localparam logic signed [SW-1:0] Q_MIN = -SW'(32768);

	logic adv;
	logic [LAT-1:0] vld_q;

	logic signed [ANGLE_W:0] yaw_ext, pitch_ext, roll_neg;
	logic signed [CS_W-1:0] c1, s1, c2, s2, c3, s3;
	logic signed [CS_W-1:0] c3_s1, s3_s1;
	logic signed [PW-1:0] c1c2_p, s1s2_p, s1c2_p, c1s2_p;
	logic signed [CS_W-1:0] c1c2_s1, s1s2_s1, s1c2_s1, c1s2_s1;
	logic signed [PW-1:0] t_s2 [0:7];
	logic signed [SW-1:0] sum_s3 [0:3];
	logic signed [SW-1:0] rnd [0:3];
	logic signed [SW-1:0] sat [0:3];
	logic [QUAT_W-1:0] quat_q [0:3];

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	assign yaw_ext = {s_axis_tdata[16], s_axis_tdata[16:0]};
	assign pitch_ext = {s_axis_tdata[33], s_axis_tdata[33:17]};
	assign roll_neg = -{s_axis_tdata[50], s_axis_tdata[50:34]};

	e2q_half_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
		.clk(clk), .en(adv), .angle(yaw_ext), .cos_val(c1), .sin_val(s1)
	);
	e2q_half_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
		.clk(clk), .en(adv), .angle(pitch_ext), .cos_val(c2), .sin_val(s2)
	);
	e2q_half_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_roll (
		.clk(clk), .en(adv), .angle(roll_neg), .cos_val(c3), .sin_val(s3)
	);

	assign c1c2_p = PW'(c1) * PW'(c2);
	assign s1s2_p = PW'(s1) * PW'(s2);
	assign s1c2_p = PW'(s1) * PW'(c2);
	assign c1s2_p = PW'(c1) * PW'(s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			c1c2_s1 <= c1c2_p[CS_W+29:30];
			s1s2_s1 <= s1s2_p[CS_W+29:30];
			s1c2_s1 <= s1c2_p[CS_W+29:30];
			c1s2_s1 <= c1s2_p[CS_W+29:30];
			c3_s1 <= c3;
			s3_s1 <= s3;
			t_s2[0] <= PW'(c1c2_s1) * PW'(c3_s1);
			t_s2[1] <= PW'(s1s2_s1) * PW'(s3_s1);
			t_s2[2] <= PW'(c1c2_s1) * PW'(s3_s1);
			t_s2[3] <= PW'(s1s2_s1) * PW'(c3_s1);
			t_s2[4] <= PW'(s1c2_s1) * PW'(c3_s1);
			t_s2[5] <= PW'(c1s2_s1) * PW'(s3_s1);
			t_s2[6] <= PW'(c1s2_s1) * PW'(c3_s1);
			t_s2[7] <= PW'(s1c2_s1) * PW'(s3_s1);
			sum_s3[0] <= SW'(t_s2[0]) - SW'(t_s2[1]);
			sum_s3[1] <= SW'(t_s2[2]) + SW'(t_s2[3]);
			sum_s3[2] <= SW'(t_s2[4]) + SW'(t_s2[5]);
			sum_s3[3] <= SW'(t_s2[6]) - SW'(t_s2[7]);
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rnd[k] = (sum_s3[k] + HALF_LSB) >>> SH;
			sat[k] = rnd[k];
			if (sat[k] > LIM) sat[k] = LIM;
			if (sat[k] < -LIM) sat[k] = -LIM;
			if (sat[k] > Q_MAX) sat[k] = Q_MAX;
			if (sat[k] < Q_MIN) sat[k] = Q_MIN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) begin
				quat_q[k] <= sat[k][QUAT_W-1:0];
			end
		end
	end

	assign m_axis_tdata = {quat_q[3], quat_q[2], quat_q[1], quat_q[0]};

	// Stage count: three divider stages, fold, CORDIC, sign fix, two products, sum, output.
	// The valid chain length LAT matches the data path depth.

endmodule

FILE: hw/rtl/e2q_div_cell.sv
// Three-stage rounded division of the scaled angle magnitude by the degree scale constant.
module e2q_div_cell import e2q_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int QB = 40 - DEF_ANGLE_FRAC_BITS
) (
	input  logic               clk,
	input  logic               en,
	input  logic [ANGLE_W-1:0] mag_i,
	input  logic               neg_i,
	output logic [QB-1:0]      quo_o,
	output logic               neg_o
);

	// The quotient splits into mag * (pi / scale) plus the rounded remainder part.
	// The scale 360 << ANGLE_FRAC_BITS is 45 times a power of two, so the remainder
	// part is a shift followed by an exact reciprocal multiply for 45.
	localparam longint DEN = longint'(360) << ANGLE_FRAC_BITS;
	localparam longint PI_L = longint'(PI_Q30);
	localparam longint QP = PI_L / DEN;
	localparam longint RP = PI_L % DEN;
	localparam int SHF = ANGLE_FRAC_BITS + 3;
	localparam int VW = 38;
	localparam int UW = 22;
	localparam int RS = 28;
	localparam int PRW = 45;
	localparam longint RECIP = ((longint'(1) << RS) + 44) / 45;

	localparam logic [QB-1:0] QP_V = QB'(QP);
	localparam logic [VW-1:0] RP_V = VW'(RP);
	localparam logic [VW-1:0] HALF_V = VW'(DEN / 2);
	localparam logic [PRW-1:0] RECIP_V = PRW'(RECIP);

	logic [QB-1:0]  pm_s1;
	logic [QB-1:0]  pm_s2;
	logic [VW-1:0]  v_s1;
	logic [PRW-1:0] prod_s2;
	logic           neg_s1;
	logic           neg_s2;
	logic [UW-1:0]  u;

	assign u = UW'(v_s1 >> SHF);

	always_ff @(posedge clk) begin
		if (en) begin
			pm_s1 <= QB'(mag_i) * QP_V;
			v_s1 <= VW'(mag_i) * RP_V + HALF_V;
			neg_s1 <= neg_i;
			pm_s2 <= pm_s1;
			prod_s2 <= PRW'(u) * RECIP_V;
			neg_s2 <= neg_s1;
			quo_o <= pm_s2 + QB'(prod_s2[PRW-1:RS]);
			neg_o <= neg_s2;
		end
	end

endmodule

FILE: hw/rtl/e2q_cordic_cell.sv
// One registered rotation-mode CORDIC micro-rotation.
module e2q_cordic_cell import e2q_pkg::*; #(
	parameter int STEP = 0,
	parameter int ZW = 36
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [CS_W-1:0] x_i,
	input  logic signed [CS_W-1:0] y_i,
	input  logic signed [ZW-1:0]   z_i,
	input  logic                   flip_i,
	output logic signed [CS_W-1:0] x_o,
	output logic signed [CS_W-1:0] y_o,
	output logic signed [ZW-1:0]   z_o,
	output logic                   flip_o
);

	localparam logic signed [ZW-1:0] DZ = ZW'(atan_q30(STEP));

	logic signed [CS_W-1:0] dx;
	logic signed [CS_W-1:0] dy;

	assign dx = y_i >>> STEP;
	assign dy = x_i >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_i >= 0) begin
				x_o <= x_i - dx;
				y_o <= y_i + dy;
				z_o <= z_i - DZ;
			end else begin
				x_o <= x_i + dx;
				y_o <= y_i - dy;
				z_o <= z_i + DZ;
			end
			flip_o <= flip_i;
		end
	end

endmodule

FILE: hw/rtl/e2q_half_angle.sv
// Half angle in radians, range fold and CORDIC chain giving cosine and sine of the half angle.
module e2q_half_angle import e2q_pkg::*; #(
	parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [ANGLE_W:0] angle,
	output logic signed [CS_W-1:0]  cos_val,
	output logic signed [CS_W-1:0]  sin_val
);

	localparam int QB = 40 - ANGLE_FRAC_BITS;
	localparam int ZW = 44 - ANGLE_FRAC_BITS;
	localparam int N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
	localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_Q30);

	logic [ANGLE_W-1:0] mag;
	logic [QB-1:0]      quo;
	logic               quo_neg;

	logic signed [CS_W-1:0] x_c [0:N];
	logic signed [CS_W-1:0] y_c [0:N];
	logic signed [ZW-1:0]   z_c [0:N];
	logic                   flip_c [0:N];

	logic signed [ZW-1:0] z_raw;
	logic signed [ZW-1:0] z_fold_q;
	logic                 flip_fold_q;

	assign mag = angle[ANGLE_W] ? ANGLE_W'(-angle) : ANGLE_W'(angle);

	e2q_div_cell #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .QB(QB)) u_div (
		.clk(clk), .en(en),
		.mag_i(mag), .neg_i(angle[ANGLE_W]),
		.quo_o(quo), .neg_o(quo_neg)
	);

	assign z_raw = quo_neg ? -ZW'(quo) : ZW'(quo);

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_raw > HALF_PI_Z) begin
				z_fold_q <= z_raw - PI_Z;
				flip_fold_q <= 1'b1;
			end else if (z_raw < -HALF_PI_Z) begin
				z_fold_q <= z_raw + PI_Z;
				flip_fold_q <= 1'b1;
			end else begin
				z_fold_q <= z_raw;
				flip_fold_q <= 1'b0;
			end
		end
	end

	assign z_c[0] = z_fold_q;
	assign flip_c[0] = flip_fold_q;
	assign x_c[0] = CS_W'(GAIN_Q30);
	assign y_c[0] = '0;

	for (genvar i = 0; i < N; i++) begin : g_rot
		e2q_cordic_cell #(.STEP(i), .ZW(ZW)) u_rot (
			.clk(clk), .en(en),
			.x_i(x_c[i]), .y_i(y_c[i]), .z_i(z_c[i]), .flip_i(flip_c[i]),
			.x_o(x_c[i+1]), .y_o(y_c[i+1]), .z_o(z_c[i+1]), .flip_o(flip_c[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= flip_c[N] ? -x_c[N] : x_c[N];
			sin_val <= flip_c[N] ? -y_c[N] : y_c[N];
		end
	end

endmodule
